// ===== hw/rtl/wsas_pkg.sv =====
// ----------------------------------------------------------------------------
// wsas_pkg
// Shared constants and codes for the weighted arrangement swap search block.
// ----------------------------------------------------------------------------
package wsas_pkg;

	localparam int MAX_VARS = 64;
	localparam int VAR_W    = $clog2(MAX_VARS);
	localparam int CNT_W    = VAR_W + 1;
	localparam int WADDR_W  = 2 * VAR_W;
	localparam int WDEPTH   = MAX_VARS * MAX_VARS;
	localparam int WGT_W    = 16;
	localparam int COST_W   = 48;
	localparam int REQ_W    = 3;
	localparam int STAT_W   = 2;

	localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

	localparam logic [REQ_W-1:0] REQ_WR_WEIGHT = 3'd0;
	localparam logic [REQ_W-1:0] REQ_WR_SLOT   = 3'd1;
	localparam logic [REQ_W-1:0] REQ_RECOMPUTE = 3'd2;
	localparam logic [REQ_W-1:0] REQ_SWAP      = 3'd3;
	localparam logic [REQ_W-1:0] REQ_RD_SLOT   = 3'd4;

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
	localparam logic [STAT_W-1:0] ST_EQUAL = 2'd2;

endpackage

// ===== hw/rtl/wsas_if.sv =====
// ----------------------------------------------------------------------------
// wsas_if
// Request and result channels: valid/ready with payload.
// ----------------------------------------------------------------------------
interface wsas_req_if;
	logic                           valid;
	logic                           ready;
	logic [wsas_pkg::REQ_W-1:0]     req_type;
	logic [wsas_pkg::VAR_W-1:0]     var_a;
	logic [wsas_pkg::VAR_W-1:0]     var_b;
	logic [wsas_pkg::WGT_W-1:0]     pair_weight;
	logic [wsas_pkg::VAR_W-1:0]     slot;
	logic [wsas_pkg::VAR_W-1:0]     slot_var;
	logic [wsas_pkg::VAR_W-1:0]     swap_first;
	logic [wsas_pkg::VAR_W-1:0]     swap_second;

	modport source (output valid, req_type, var_a, var_b, pair_weight, slot, slot_var,
		swap_first, swap_second, input ready);
	modport sink (input valid, req_type, var_a, var_b, pair_weight, slot, slot_var,
		swap_first, swap_second, output ready);
endinterface

interface wsas_res_if;
	logic                           valid;
	logic                           ready;
	logic [wsas_pkg::COST_W-1:0]    cost;
	logic                           swap_taken;
	logic [wsas_pkg::VAR_W-1:0]     read_var;
	logic [wsas_pkg::STAT_W-1:0]    status;

	modport source (output valid, cost, swap_taken, read_var, status, input ready);
	modport sink (input valid, cost, swap_taken, read_var, status, output ready);
endinterface

// ===== hw/rtl/wsas_ram.sv =====
// ----------------------------------------------------------------------------
// wsas_ram
// Generic one-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module wsas_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hw/rtl/weighted_arrangement_swap_search.sv =====
// ----------------------------------------------------------------------------
// weighted_arrangement_swap_search
// Pair-weight table, variable ordering and arrangement cost with swap search.
// ----------------------------------------------------------------------------
// Usage:
//  req (sink) takes one request word when valid and ready are high; res
//  (source) returns exactly one result word per request. cfg_we/cfg_wdata
//  set vars_in_use (n, clamped to 2..64); write it only while idle.
//  One shared 18x14 multiplier and two accumulators (sum and delta) run
//  under a sequencer; the weight table (4096 x 16) and the ordering (64 x 6)
//  are RAMs with one read port each, so the reads of each RAM are issued
//  one at a time by the sequencer.
//  Only one request is worked on at a time; ready is low meanwhile and comes
//  back as the result word is loaded into the output register.
//  Reset: a clearing pass over all 4096 weight addresses zeroes the weight
//  table and loads the identity ordering; no request is accepted until it
//  ends. Cost resets to zero.
//  A stalled result waits in the output register; the next request may be
//  accepted and worked on, and its result is held until the register frees.
// ----------------------------------------------------------------------------
module weighted_arrangement_swap_search (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [6:0]              cfg_wdata,
	wsas_req_if.sink                req,
	wsas_res_if.source              res
);

	localparam int VW = wsas_pkg::VAR_W;
	localparam int CW = wsas_pkg::CNT_W;
	localparam int AW = wsas_pkg::WADDR_W;

	typedef enum logic [4:0] {
		CLR, IDLE, WW1, WW2, OW, R1, R2,
		C_I, C_I2, C_J, C_J2, C_W, C_ACC,
		S_P, S_Q, S_Q2, S_I, S_W1, S_W2, S_M, S_ACC, S_DEC, S_DEC2,
		FIN
	} state_t;

	state_t st_q;
	state_t idle_st;
	logic [wsas_pkg::STAT_W-1:0] idle_status;

	logic [6:0]              vars_q;
	logic [CW-1:0]           n;
	logic [AW-1:0]           clr_q;

	logic [VW-1:0]           a_q, b_q, slot_q, svar_q, p_q, q_q;
	logic [wsas_pkg::WGT_W-1:0] pw_q, wp_q;
	logic [CW-1:0]           i_q, j_q;
	logic [VW-1:0]           oi_q, op_q, oq_q;
	logic signed [13:0]      dd_q;
	logic signed [39:0]      delta_q;
	logic [wsas_pkg::COST_W-1:0] sum_q, cost_q;
	logic signed [31:0]      prod_q;

	logic                    taken_q;
	logic [VW-1:0]           rvar_q;
	logic [wsas_pkg::STAT_W-1:0] status_q;

	logic                    out_valid_q;
	logic [wsas_pkg::COST_W-1:0] out_cost_q;
	logic                    out_taken_q;
	logic [VW-1:0]           out_rvar_q;
	logic [wsas_pkg::STAT_W-1:0] out_status_q;

	// RAM ports
	logic                    w_we, o_we;
	logic [AW-1:0]           w_wa, w_ra;
	logic [wsas_pkg::WGT_W-1:0] w_wd, w_rd;
	logic [VW-1:0]           o_wa, o_ra, o_wd, o_rd;

	// shared multiplier
	logic signed [17:0]      mul_a;
	logic signed [13:0]      mul_b;
	logic signed [31:0]      mul_p;

	logic signed [7:0]       pq_diff;
	logic signed [8:0]       pos_sum;
	logic [CW-1:0]           pair_dist;
	logic [wsas_pkg::COST_W:0] sum_nx;
	logic signed [40:0]      cost_nx;

	wsas_ram #(.WIDTH(wsas_pkg::WGT_W), .DEPTH(wsas_pkg::WDEPTH)) u_wram (
		.clk(clk), .we(w_we), .waddr(w_wa), .wdata(w_wd), .raddr(w_ra), .rdata(w_rd)
	);

	wsas_ram #(.WIDTH(VW), .DEPTH(wsas_pkg::MAX_VARS)) u_oram (
		.clk(clk), .we(o_we), .waddr(o_wa), .wdata(o_wd), .raddr(o_ra), .rdata(o_rd)
	);

	always_comb begin
		if (vars_q < 7'd2) begin
			n = CW'(2);
		end else if (vars_q > 7'(wsas_pkg::MAX_VARS)) begin
			n = CW'(wsas_pkg::MAX_VARS);
		end else begin
			n = CW'(vars_q);
		end
	end

	// request decode: range and equal-index checks pick the first state and status
	always_comb begin
		idle_st     = FIN;
		idle_status = wsas_pkg::ST_OK;
		unique case (req.req_type)
			wsas_pkg::REQ_WR_WEIGHT: begin
				if (CW'(req.var_a) >= n || CW'(req.var_b) >= n) begin
					idle_status = wsas_pkg::ST_RANGE;
				end else begin
					idle_st = WW1;
				end
			end
			wsas_pkg::REQ_WR_SLOT: begin
				if (CW'(req.slot) >= n || CW'(req.slot_var) >= n) begin
					idle_status = wsas_pkg::ST_RANGE;
				end else begin
					idle_st = OW;
				end
			end
			wsas_pkg::REQ_RECOMPUTE: idle_st = C_I;
			wsas_pkg::REQ_SWAP: begin
				if (CW'(req.swap_first) >= n || CW'(req.swap_second) >= n) begin
					idle_status = wsas_pkg::ST_RANGE;
				end else if (req.swap_first == req.swap_second) begin
					idle_status = wsas_pkg::ST_EQUAL;
				end else begin
					idle_st = S_P;
				end
			end
			wsas_pkg::REQ_RD_SLOT: begin
				if (CW'(req.slot) >= n) begin
					idle_status = wsas_pkg::ST_RANGE;
				end else begin
					idle_st = R1;
				end
			end
			default: ;
		endcase
	end

	assign pq_diff   = $signed({2'b00, p_q}) - $signed({2'b00, q_q});
	assign pos_sum   = $signed({2'b00, i_q[VW-1:0], 1'b0}) - $signed({3'b000, p_q})
		- $signed({3'b000, q_q});
	assign pair_dist = j_q - i_q;
	assign mul_p     = mul_a * mul_b;
	assign sum_nx    = {1'b0, sum_q} + (wsas_pkg::COST_W+1)'(unsigned'(prod_q));
	assign cost_nx   = $signed({1'b0, cost_q[39:0]}) + 41'(delta_q);

	always_comb begin
		w_we  = 1'b0;
		w_wa  = '0;
		w_wd  = '0;
		w_ra  = '0;
		o_we  = 1'b0;
		o_wa  = '0;
		o_wd  = '0;
		o_ra  = '0;
		mul_a = '0;
		mul_b = '0;
		unique case (st_q)
			CLR: begin
				w_we = 1'b1;
				w_wa = clr_q;
				o_we = (clr_q[AW-1:VW] == '0);
				o_wa = clr_q[VW-1:0];
				o_wd = clr_q[VW-1:0];
			end
			WW1: begin
				w_we = 1'b1;
				w_wa = {a_q, b_q};
				w_wd = pw_q;
			end
			WW2: begin
				w_we = 1'b1;
				w_wa = {b_q, a_q};
				w_wd = pw_q;
			end
			OW: begin
				o_we = 1'b1;
				o_wa = slot_q;
				o_wd = svar_q;
			end
			R1:   o_ra = slot_q;
			C_I:  o_ra = i_q[VW-1:0];
			C_J:  o_ra = j_q[VW-1:0];
			C_J2: begin
				w_ra  = {oi_q, o_rd};
				mul_a = 18'(pair_dist);
				mul_b = 14'(pair_dist);
			end
			C_W: begin
				mul_a = 18'(w_rd);
				mul_b = prod_q[13:0];
			end
			S_P:  o_ra = p_q;
			S_Q:  o_ra = q_q;
			S_I: begin
				o_ra  = i_q[VW-1:0];
				mul_a = 18'(pq_diff);
				mul_b = 14'(pos_sum);
			end
			S_W1: w_ra = {o_rd, op_q};
			S_W2: w_ra = {oi_q, oq_q};
			S_M: begin
				mul_a = 18'($signed({1'b0, wp_q}) - $signed({1'b0, w_rd}));
				mul_b = dd_q;
			end
			S_DEC: begin
				o_we = delta_q[39];
				o_wa = p_q;
				o_wd = oq_q;
			end
			S_DEC2: begin
				o_we = 1'b1;
				o_wa = q_q;
				o_wd = op_q;
			end
			default: ;
		endcase
	end

	assign req.ready      = (st_q == IDLE);
	assign res.valid      = out_valid_q;
	assign res.cost       = out_cost_q;
	assign res.swap_taken = out_taken_q;
	assign res.read_var   = out_rvar_q;
	assign res.status     = out_status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= CLR;
			vars_q      <= 7'd64;
			clr_q       <= '0;
			cost_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				vars_q <= cfg_wdata;
			end
			if (st_q == FIN && (!out_valid_q || res.ready)) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
			if (st_q == C_J2 || st_q == C_W || st_q == S_I || st_q == S_M) begin
				prod_q <= mul_p;
			end
			unique case (st_q)
				CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1) begin
						st_q <= IDLE;
					end
				end
				IDLE: begin
					if (req.valid) begin
						a_q      <= req.var_a;
						b_q      <= req.var_b;
						pw_q     <= req.pair_weight;
						slot_q   <= req.slot;
						svar_q   <= req.slot_var;
						p_q      <= req.swap_first;
						q_q      <= req.swap_second;
						taken_q  <= 1'b0;
						rvar_q   <= '0;
						status_q <= idle_status;
						i_q      <= '0;
						sum_q    <= '0;
						delta_q  <= '0;
						st_q     <= idle_st;
					end
				end
				WW1: st_q <= WW2;
				WW2: st_q <= FIN;
				OW:  st_q <= FIN;
				R1:  st_q <= R2;
				R2: begin
					rvar_q <= o_rd;
					st_q   <= FIN;
				end
				// full recompute: outer i, inner j > i
				C_I:  st_q <= C_I2;
				C_I2: begin
					oi_q <= o_rd;
					j_q  <= i_q + 1'b1;
					st_q <= C_J;
				end
				C_J:  st_q <= C_J2;
				C_J2: st_q <= C_W;
				C_W:  st_q <= C_ACC;
				C_ACC: begin
					sum_q <= sum_nx[wsas_pkg::COST_W] ? wsas_pkg::COST_MAX
						: sum_nx[wsas_pkg::COST_W-1:0];
					if (j_q + 1'b1 < n) begin
						j_q  <= j_q + 1'b1;
						st_q <= C_J;
					end else if (i_q + 2'd2 < n) begin
						i_q  <= i_q + 1'b1;
						st_q <= C_I;
					end else begin
						cost_q <= sum_nx[wsas_pkg::COST_W] ? wsas_pkg::COST_MAX
							: sum_nx[wsas_pkg::COST_W-1:0];
						st_q   <= FIN;
					end
				end
				// swap: delta = sum (w(i,p) - w(i,q)) * (p-q)(2i-p-q)
				S_P: st_q <= S_Q;
				S_Q: begin
					op_q <= o_rd;
					st_q <= S_Q2;
				end
				S_Q2: begin
					oq_q <= o_rd;
					st_q <= S_I;
				end
				S_I: begin
					if (i_q == n) begin
						st_q <= S_DEC;
					end else if (i_q[VW-1:0] == p_q || i_q[VW-1:0] == q_q) begin
						i_q <= i_q + 1'b1;
					end else begin
						st_q <= S_W1;
					end
				end
				S_W1: begin
					oi_q <= o_rd;
					dd_q <= prod_q[13:0];
					st_q <= S_W2;
				end
				S_W2: begin
					wp_q <= w_rd;
					st_q <= S_M;
				end
				S_M: st_q <= S_ACC;
				S_ACC: begin
					delta_q <= delta_q + 40'(prod_q);
					i_q     <= i_q + 1'b1;
					st_q    <= S_I;
				end
				S_DEC: begin
					if (delta_q[39]) begin
						// a cost of 2^40 or more cannot go negative; smaller ones floor at zero
						if (cost_q[wsas_pkg::COST_W-1:40] != '0) begin
							cost_q <= cost_q + wsas_pkg::COST_W'(delta_q);
						end else if (cost_nx[40]) begin
							cost_q <= '0;
						end else begin
							cost_q <= wsas_pkg::COST_W'(cost_nx[39:0]);
						end
						taken_q <= 1'b1;
						st_q    <= S_DEC2;
					end else begin
						st_q <= FIN;
					end
				end
				S_DEC2: st_q <= FIN;
				FIN: begin
					if (!out_valid_q || res.ready) begin
						out_cost_q   <= cost_q;
						out_taken_q  <= taken_q;
						out_rvar_q   <= rvar_q;
						out_status_q <= status_q;
						st_q         <= IDLE;
					end
				end
				default: st_q <= IDLE;
			endcase
		end
	end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Bench for weighted_arrangement_swap_search. Requests are queued, driven
// with random gaps and checked one for one against an in-bench predictor of
// the weight table, ordering and cost. Runs several vars_in_use settings.
// ----------------------------------------------------------------------------
module tb;

	localparam int MAXV  = wsas_pkg::MAX_VARS;
	localparam int VW    = wsas_pkg::VAR_W;
	localparam int WW    = wsas_pkg::WGT_W;
	localparam int CSTW  = wsas_pkg::COST_W;
	localparam int RW    = wsas_pkg::REQ_W;
	localparam int SW    = wsas_pkg::STAT_W;

	typedef struct packed {
		logic [RW-1:0] req_type;
		logic [VW-1:0] var_a;
		logic [VW-1:0] var_b;
		logic [WW-1:0] pair_weight;
		logic [VW-1:0] slot;
		logic [VW-1:0] slot_var;
		logic [VW-1:0] swap_first;
		logic [VW-1:0] swap_second;
	} req_word_t;

	typedef struct packed {
		logic [CSTW-1:0] cost;
		logic            swap_taken;
		logic [VW-1:0]   read_var;
		logic [SW-1:0]   status;
	} res_word_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [6:0] cfg_wdata;

	wsas_req_if req ();
	wsas_res_if res ();

	weighted_arrangement_swap_search uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req),
		.res       (res)
	);

	// predictor state
	logic [WW-1:0]   pw_table [MAXV][MAXV];
	logic [VW-1:0]   order_model [MAXV];
	logic [CSTW-1:0] arr_cost;
	int              active_n;

	req_word_t pending_reqs [$];
	res_word_t expected_res [$];
	int  errors = 0;
	int  gap_left;
	int  hold_left;
	bit  hold_done;
	int  results_seen = 0;
	bit  quiet;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	task automatic report_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
		errors++;
	endtask

	task automatic add_req(input req_word_t r);
		pending_reqs = {pending_reqs, r};
	endtask

	function automatic int clamp_n(input logic [6:0] v);
		if (v < 2) return 2;
		if (v > MAXV) return MAXV;
		return int'(v);
	endfunction

	task automatic apply_req(input req_word_t r);
		res_word_t e;
		logic [63:0] sum;
		logic [63:0] w;
		longint delta;
		longint dp;
		longint dq;
		longint nxt;
		logic [VW-1:0] t;
		int p;
		int q;
		e = '0;
		p = int'(r.swap_first);
		q = int'(r.swap_second);
		case (r.req_type)
			wsas_pkg::REQ_WR_WEIGHT: begin
				if (int'(r.var_a) >= active_n || int'(r.var_b) >= active_n)
					e.status = wsas_pkg::ST_RANGE;
				else begin
					pw_table[r.var_a][r.var_b] = r.pair_weight;
					pw_table[r.var_b][r.var_a] = r.pair_weight;
				end
			end
			wsas_pkg::REQ_WR_SLOT: begin
				if (int'(r.slot) >= active_n || int'(r.slot_var) >= active_n)
					e.status = wsas_pkg::ST_RANGE;
				else order_model[r.slot] = r.slot_var;
			end
			wsas_pkg::REQ_RECOMPUTE: begin
				sum = 0;
				for (int i = 0; i + 1 < active_n; i++)
					for (int j = i + 1; j < active_n; j++) begin
						w = 64'(pw_table[order_model[i]][order_model[j]]);
						sum += w * 64'(j - i) * 64'(j - i);
						if (sum > wsas_pkg::COST_MAX) sum = 64'(wsas_pkg::COST_MAX);
					end
				arr_cost = sum[CSTW-1:0];
			end
			wsas_pkg::REQ_SWAP: begin
				if (p >= active_n || q >= active_n) e.status = wsas_pkg::ST_RANGE;
				else if (p == q) e.status = wsas_pkg::ST_EQUAL;
				else begin
					delta = 0;
					for (int i = 0; i < active_n; i++) begin
						if (i == p || i == q) continue;
						dp = longint'((i - p) * (i - p));
						dq = longint'((i - q) * (i - q));
						delta += longint'(pw_table[order_model[i]][order_model[p]]) * (dq - dp);
						delta += longint'(pw_table[order_model[i]][order_model[q]]) * (dp - dq);
					end
					if (delta < 0) begin
						nxt = longint'({16'b0, arr_cost}) + delta;
						t = order_model[p];
						order_model[p] = order_model[q];
						order_model[q] = t;
						if (nxt < 0) nxt = 0;
						arr_cost = nxt[CSTW-1:0];
						e.swap_taken = 1'b1;
					end
				end
			end
			wsas_pkg::REQ_RD_SLOT: begin
				if (int'(r.slot) >= active_n) e.status = wsas_pkg::ST_RANGE;
				else e.read_var = order_model[r.slot];
			end
			default: ;
		endcase
		e.cost = arr_cost;
		expected_res = {expected_res, e};
	endtask

	function automatic logic [VW-1:0] pick_index(input int n);
		if ($urandom_range(0, 9) == 0) return VW'($urandom_range(0, MAXV - 1));
		return VW'($urandom_range(0, n - 1));
	endfunction

	function automatic req_word_t random_req(input int n);
		req_word_t r;
		int k;
		r = req_word_t'({$urandom, $urandom});
		k = $urandom_range(0, 999);
		if (k < 300) begin
			r.req_type = wsas_pkg::REQ_WR_WEIGHT;
			r.var_a = pick_index(n);
			r.var_b = pick_index(n);
			if ($urandom_range(0, 3) == 0) r.pair_weight = WW'($urandom_range(0, 255));
		end else if (k < 450) begin
			r.req_type = wsas_pkg::REQ_WR_SLOT;
			r.slot = pick_index(n);
			r.slot_var = pick_index(n);
		end else if (k < 830) begin
			r.req_type = wsas_pkg::REQ_SWAP;
			r.swap_first = pick_index(n);
			r.swap_second = ($urandom_range(0, 19) == 0) ? r.swap_first : pick_index(n);
		end else if (k < 960) begin
			r.req_type = wsas_pkg::REQ_RD_SLOT;
			r.slot = pick_index(n);
		end else if (k < 980) begin
			// full recompute is slow at large n; keep it rare there
			r.req_type = (n <= 16 || $urandom_range(0, 5) == 0) ? wsas_pkg::REQ_RECOMPUTE
				: wsas_pkg::REQ_SWAP;
		end else begin
			r.req_type = RW'($urandom_range(5, 7));
		end
		return r;
	endfunction

	function automatic req_word_t mk(input logic [RW-1:0] op, input int a, input int b,
		input int w);
		req_word_t r;
		r = req_word_t'({$urandom, $urandom});
		r.req_type = op;
		r.var_a = VW'(a);
		r.var_b = VW'(b);
		r.slot = VW'(a);
		r.slot_var = VW'(b);
		r.swap_first = VW'(a);
		r.swap_second = VW'(b);
		r.pair_weight = WW'(w);
		return r;
	endfunction

	function automatic int next_gap();
		int k;
		if (quiet) return 0;
		k = $urandom_range(0, 99);
		if (k < 55) return 0;
		if (k < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 60);
	endfunction

	// request driver; outside quiet phases valid drops after each accept and stays low for a random gap
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid       <= 1'b0;
			req.req_type    <= '0;
			req.var_a       <= '0;
			req.var_b       <= '0;
			req.pair_weight <= '0;
			req.slot        <= '0;
			req.slot_var    <= '0;
			req.swap_first  <= '0;
			req.swap_second <= '0;
			gap_left        <= 0;
		end else begin
			bit took;
			took = req.valid && req.ready;
			if (took) begin
				apply_req(pending_reqs.pop_front());
				gap_left <= next_gap();
			end
			if (req.valid && !took) begin
				req.valid <= 1'b1;
			end else if (took ? !quiet : (gap_left > 0)) begin
				req.valid <= 1'b0;
				if (!took) gap_left <= gap_left - 1;
			end else if (pending_reqs.size() > 0) begin
				req.valid <= 1'b1;
				{req.req_type, req.var_a, req.var_b, req.pair_weight, req.slot,
					req.slot_var, req.swap_first, req.swap_second} <= pending_reqs[0];
			end else begin
				req.valid <= 1'b0;
			end
		end
	end

	// result side: random stalls plus one long hold-off to back the block up
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res.ready <= 1'b0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done && results_seen == 120) begin
			hold_done <= 1'b1;
			hold_left <= 600;
			res.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			res.ready <= 1'b0;
		end else if (quiet) begin
			res.ready <= 1'b1;
		end else if ($urandom_range(0, 49) == 0) begin
			hold_left <= $urandom_range(10, 50);
			res.ready <= 1'b0;
		end else begin
			res.ready <= ($urandom_range(0, 3) != 0);
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && res.valid && res.ready) begin
			res_word_t e;
			results_seen <= results_seen + 1;
			if (expected_res.size() == 0) begin
				report_mismatch("unexpected word", 64'({res.cost, res.status}), 64'd0);
			end else begin
				e = expected_res.pop_front();
				if (res.cost !== e.cost)
					report_mismatch("cost", 64'(res.cost), 64'(e.cost));
				if (res.swap_taken !== e.swap_taken)
					report_mismatch("swap_taken", 64'(res.swap_taken), 64'(e.swap_taken));
				if (res.read_var !== e.read_var)
					report_mismatch("read_var", 64'(res.read_var), 64'(e.read_var));
				if (res.status !== e.status)
					report_mismatch("status", 64'(res.status), 64'(e.status));
			end
		end
	end

	task automatic wait_drained();
		while (pending_reqs.size() > 0 || expected_res.size() > 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_vars(input logic [6:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		active_n = clamp_n(v);
	endtask

	logic [6:0] phase_vals [9] = '{7'd64, 7'd2, 7'd0, 7'd5, 7'd16, 7'd127, 7'd1, 7'd40, 7'd64};

	initial begin
		quiet = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 7'd0;
		for (int i = 0; i < MAXV; i++) begin
			order_model[i] = VW'(i);
			for (int j = 0; j < MAXV; j++) pw_table[i][j] = '0;
		end
		arr_cost = '0;
		active_n = MAXV;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed: field extremes, every op, self weight, equal swap, odd codes
		add_req(mk(wsas_pkg::REQ_RD_SLOT, 63, 0, 0));
		add_req(mk(wsas_pkg::REQ_WR_WEIGHT, 63, 63, 16'hFFFF));
		add_req(mk(wsas_pkg::REQ_WR_WEIGHT, 0, 63, 16'hFFFF));
		add_req(mk(wsas_pkg::REQ_WR_WEIGHT, 1, 62, 16'h0001));
		add_req(mk(wsas_pkg::REQ_WR_WEIGHT, 1, 62, 16'h0000));
		add_req(mk(wsas_pkg::REQ_WR_WEIGHT, 0, 1, 16'h8000));
		add_req(mk(wsas_pkg::REQ_WR_SLOT, 0, 63, 0));
		add_req(mk(wsas_pkg::REQ_WR_SLOT, 62, 63, 0));
		add_req(mk(wsas_pkg::REQ_RD_SLOT, 0, 0, 0));
		add_req(mk(wsas_pkg::REQ_RECOMPUTE, 0, 0, 0));
		add_req(mk(wsas_pkg::REQ_SWAP, 0, 63, 0));
		add_req(mk(wsas_pkg::REQ_SWAP, 63, 1, 0));
		add_req(mk(wsas_pkg::REQ_SWAP, 5, 5, 0));
		add_req(mk(3'd5, 0, 0, 0));
		add_req(mk(3'd6, 0, 0, 0));
		add_req(mk(3'd7, 0, 0, 0));
		add_req(mk(wsas_pkg::REQ_RD_SLOT, 62, 0, 0));
		add_req(mk(wsas_pkg::REQ_SWAP, 0, 62, 0));
		wait_drained();

		for (int ph = 0; ph < 9; ph++) begin
			if (ph > 0) set_vars(phase_vals[ph]);
			quiet = (ph % 3 == 2);
			if (ph == 1) begin
				// n is 2: out-of-range for each op that checks its indices
				add_req(mk(wsas_pkg::REQ_WR_WEIGHT, 2, 0, 16'h1234));
				add_req(mk(wsas_pkg::REQ_WR_WEIGHT, 0, 63, 16'h1234));
				add_req(mk(wsas_pkg::REQ_WR_SLOT, 2, 0, 0));
				add_req(mk(wsas_pkg::REQ_WR_SLOT, 0, 2, 0));
				add_req(mk(wsas_pkg::REQ_RD_SLOT, 2, 0, 0));
				add_req(mk(wsas_pkg::REQ_SWAP, 0, 2, 0));
				add_req(mk(wsas_pkg::REQ_SWAP, 63, 1, 0));
			end
			for (int k = 0; k < 160; k++) add_req(random_req(active_n));
			// make sure the stale cost gets refreshed now and then
			add_req(mk(wsas_pkg::REQ_RECOMPUTE, 0, 0, 0));
			for (int k = 0; k < 10; k++) add_req(random_req(active_n));
			wait_drained();
		end

		repeat (50) @(posedge clk);
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	initial begin
		#50ms;
		$display("FAIL");
		$finish;
	end

endmodule

// ===== weighted_arrangement_swap_search.f =====
hw/rtl/wsas_pkg.sv
hw/rtl/wsas_if.sv
hw/rtl/wsas_ram.sv
hw/rtl/weighted_arrangement_swap_search.sv
bench/tb.sv
